// ----- sv/popw_pkg.sv -----
// Shared constants, types and arithmetic helpers for the vertex projection engine.
package popw_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_BITS = 32;

    localparam int W    = WORD_BITS;
    localparam int PW   = 2 * W - FRAC_BITS;   // rounded product width
    localparam int SATW = 2 * W + 4;           // working width ahead of saturation
    localparam int DSTG = W / 2;               // divider stages, two quotient bits each

    localparam int STORE_WORDS = 32;
    localparam int IDX_BITS    = $clog2(STORE_WORDS);

    localparam int CFG_BITS     = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int VP_BITS      = 15;

    localparam logic [CFG_IDX_BITS-1:0] REG_VP_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_VP_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_VP_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_VP_HEIGHT   = 2'd3;

    localparam logic [VP_BITS-1:0] VP_WIDTH_RST  = 15'd640;
    localparam logic [VP_BITS-1:0] VP_HEIGHT_RST = 15'd480;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_POINT = 1'b1;

    localparam logic signed [SATW-1:0] SAT_HI = {{(SATW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [SATW-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [W:0]      ONE_Q  = (W+1)'(1) <<< FRAC_BITS;

    typedef struct packed {
        logic                ld;
        logic [IDX_BITS-1:0] idx;
        logic [W-1:0]        val;
    } ldc_t;

    typedef struct packed {
        logic [W-1:0] r;
        logic [W-1:0] q;
    } divst_t;

    typedef struct packed {
        divst_t [2:0] ln;
        logic [W-1:0] d;
        logic [2:0]   neg;
        logic [2:0]   ovf;
        logic         wz;
    } dpipe_t;

    function automatic logic signed [W-1:0] sat_w(input logic signed [SATW-1:0] v);
        logic signed [W-1:0] o;
        if (v > SAT_HI)
            o = {1'b0, {(W-1){1'b1}}};
        else if (v < SAT_LO)
            o = {1'b1, {(W-1){1'b0}}};
        else
            o = v[W-1:0];
        return o;
    endfunction

    // Shift right by FRAC_BITS, nearest with ties away from zero.
    function automatic logic signed [PW-1:0] rnd_prod(input logic signed [2*W-1:0] p);
        logic signed [2*W-1:0] t;
        t = p + ((2*W)'(1) <<< (FRAC_BITS - 1)) - (2*W)'(p[2*W-1]);
        return t[2*W-1:FRAC_BITS];
    endfunction

    // One restoring division step.
    function automatic divst_t div_step(input divst_t s, input logic [W-1:0] d);
        divst_t     o;
        logic [W:0] t;
        logic       b;
        t = {s.r, s.q[W-1]};
        b = (t >= {1'b0, d});
        o.r = b ? W'(t - {1'b0, d}) : t[W-1:0];
        o.q = {s.q[W-2:0], b};
        return o;
    endfunction

    function automatic logic [W-1:0] mag_w(input logic signed [W-1:0] v);
        return v[W-1] ? W'(-v) : W'(v);
    endfunction

endpackage

// ----- sv/project_object_point_to_window_top.sv -----
// Vertex projection engine: matrix store, transform pipeline, divider and viewport map.
//
// Input stream (s_*): s_tuser selects the request kind. A load request writes one
// word of the model-view (index 0-15) or projection (16-31) matrix, column-major;
// a point request carries object x, y, z and yields one result on the output
// stream (m_*). Loads yield nothing. The configuration port sets the viewport
// origin and size and is written while the pipeline is empty.
// Throughput is one request per cycle while the output does not stall. After the
// capture stage, a point passes two multiply stages, two round stages and two sum
// stages for the matrices, a setup stage, a 16-stage radix-2x2 divider, and three
// viewport stages. Loads take effect in order with the points around them.
// The pipeline stalls stage by stage: a full stage holds when the one ahead of it
// holds, bubbles close up, and s_tready stays high while empty stages remain, so
// new requests enter while a finished result waits in the output register.
// Reset clears the matrix store to zero, the viewport to origin 0,0 and size
// 640x480, and empties the pipeline. m_tuser is 0 when clip w was zero.
module project_object_point_to_window_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [popw_pkg::CFG_IDX_BITS-1:0]      cfg_addr,
    input  logic [popw_pkg::CFG_BITS-1:0]          cfg_wdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic                                   s_tuser,   // mode
    input  logic [135:0]                           s_tdata,   // word_index, word_value, obj_x, obj_y, obj_z
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic                                   m_tuser,   // point_ok
    output logic [95:0]                            m_tdata    // win_x, win_y, win_z
);
    import popw_pkg::*;

    localparam int S_LOAD = 5;                  // first stage that carries points only
    localparam int S_DIV0 = 8;
    localparam int S_N    = S_DIV0 + DSTG + 1;
    localparam int S_PROD = S_N + 1;
    localparam int NST    = S_PROD + 1;

    // viewport registers
    logic signed [CFG_BITS-1:0] org_x_reg, org_y_reg;
    logic [VP_BITS-1:0]         vp_w_reg, vp_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg <= '0;
            org_y_reg <= '0;
            vp_w_reg  <= VP_WIDTH_RST;
            vp_h_reg  <= VP_HEIGHT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_VP_ORIGIN_X: org_x_reg <= cfg_wdata;
                REG_VP_ORIGIN_Y: org_y_reg <= cfg_wdata;
                REG_VP_WIDTH:    vp_w_reg  <= cfg_wdata[VP_BITS-1:0];
                REG_VP_HEIGHT:   vp_h_reg  <= cfg_wdata[VP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // stage control
    logic [NST:1] v_reg, v_next, en;

    always_comb
    begin
        en[NST] = !v_reg[NST] || m_tready;
        for (int k = NST - 1; k >= 1; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    // stage payloads
    logic                       mode1_reg;
    logic [IDX_BITS-1:0]        idx1_reg;
    logic [W-1:0]               val1_reg;
    logic signed [W-1:0]        obj_reg [0:2];
    ldc_t                       ldc2_reg, ldc3_reg, ldc4_reg;
    logic signed [2*W-1:0]      mvp_reg [0:3][0:2];
    logic signed [W-1:0]        mvt_reg [0:3];
    logic signed [PW-1:0]       mvr_reg [0:3][0:3];
    logic signed [W-1:0]        eye_reg [0:3];
    logic signed [2*W-1:0]      pp_reg  [0:3][0:3];
    logic signed [PW-1:0]       pr_reg  [0:3][0:3];
    logic signed [W-1:0]        clip_reg[0:3];
    dpipe_t                     dp_reg  [0:DSTG];
    logic signed [W-1:0]        n_reg   [0:2];
    logic                       wz_n_reg, wz_p_reg;
    logic signed [W+16:0]       px_reg, py_reg;
    logic signed [W:0]          pz_reg;
    logic                       ok_reg;
    logic signed [W-1:0]        wx_reg, wy_reg, wz_reg;
    logic [W-1:0]               mat_reg [0:STORE_WORDS-1];

    always_comb
    begin
        for (int k = 1; k <= NST; k++)
        begin
            if (!en[k])
                v_next[k] = v_reg[k];
            else if (k == 1)
                v_next[k] = s_tvalid;
            else if (k == S_LOAD)
                v_next[k] = v_reg[k-1] && !ldc4_reg.ld;
            else
                v_next[k] = v_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    // matrix store: model-view words are written as a load leaves stage 1,
    // projection words as it leaves stage 4, where each matrix is read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_WORDS; i++)
                mat_reg[i] <= '0;
        end
        else
        begin
            if (en[2] && v_reg[1] && mode1_reg == MODE_LOAD && !idx1_reg[IDX_BITS-1])
                mat_reg[idx1_reg] <= val1_reg;
            if (en[S_LOAD] && v_reg[4] && ldc4_reg.ld && ldc4_reg.idx[IDX_BITS-1])
                mat_reg[ldc4_reg.idx] <= ldc4_reg.val;
        end
    end

    // stage 1: capture request
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            mode1_reg  <= s_tuser;
            idx1_reg   <= s_tdata[4:0];
            val1_reg   <= s_tdata[36:5];
            obj_reg[0] <= s_tdata[68:37];
            obj_reg[1] <= s_tdata[100:69];
            obj_reg[2] <= s_tdata[132:101];
        end
    end

    // stages 2-4: model-view transform
    ldc_t ldc2_next;
    logic signed [PW+1:0] esum_next [0:3];

    always_comb
    begin
        ldc2_next.ld  = (mode1_reg == MODE_LOAD);
        ldc2_next.idx = idx1_reg;
        ldc2_next.val = val1_reg;
        for (int r = 0; r < 4; r++)
            esum_next[r] = (PW+2)'(mvr_reg[r][0]) + (PW+2)'(mvr_reg[r][1])
                         + (PW+2)'(mvr_reg[r][2]) + (PW+2)'(mvr_reg[r][3]);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            ldc2_reg <= ldc2_next;
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 3; c++)
                    mvp_reg[r][c] <= $signed(mat_reg[4*c+r]) * obj_reg[c];
                mvt_reg[r] <= $signed(mat_reg[12+r]);
            end
        end
        if (en[3])
        begin
            ldc3_reg <= ldc2_reg;
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 3; c++)
                    mvr_reg[r][c] <= rnd_prod(mvp_reg[r][c]);
                mvr_reg[r][3] <= PW'(mvt_reg[r]);
            end
        end
        if (en[4])
        begin
            ldc4_reg <= ldc3_reg;
            for (int r = 0; r < 4; r++)
                eye_reg[r] <= sat_w(SATW'(esum_next[r]));
        end
    end

    // stages 5-7: projection transform
    logic signed [PW+1:0] csum_next [0:3];

    always_comb
    begin
        for (int r = 0; r < 4; r++)
            csum_next[r] = (PW+2)'(pr_reg[r][0]) + (PW+2)'(pr_reg[r][1])
                         + (PW+2)'(pr_reg[r][2]) + (PW+2)'(pr_reg[r][3]);
    end

    always_ff @(posedge clk)
    begin
        if (en[S_LOAD])
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    pp_reg[r][c] <= $signed(mat_reg[16+4*c+r]) * eye_reg[c];
        if (en[6])
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    pr_reg[r][c] <= rnd_prod(pp_reg[r][c]);
        if (en[7])
            for (int r = 0; r < 4; r++)
                clip_reg[r] <= sat_w(SATW'(csum_next[r]));
    end

    // stage 8: divider setup, quotient of un * 2^(F+1) / ud in W steps
    dpipe_t dp0_next;
    logic [W-1:0] un;

    always_comb
    begin
        dp0_next.d  = mag_w(clip_reg[3]);
        dp0_next.wz = (clip_reg[3] == '0);
        un = '0;
        for (int i = 0; i < 3; i++)
        begin
            un = mag_w(clip_reg[i]);
            dp0_next.neg[i]  = clip_reg[i][W-1] ^ clip_reg[3][W-1];
            dp0_next.ovf[i]  = ((2*W)'(un) >= ((2*W)'(dp0_next.d) << (W - 1 - FRAC_BITS)));
            dp0_next.ln[i].r = un >> (W - FRAC_BITS - 1);
            dp0_next.ln[i].q = W'(un << (FRAC_BITS + 1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_DIV0])
            dp_reg[0] <= dp0_next;
    end

    function automatic dpipe_t dp_adv(input dpipe_t s);
        dpipe_t o;
        o = s;
        for (int i = 0; i < 3; i++)
            o.ln[i] = div_step(div_step(s.ln[i], s.d), s.d);
        return o;
    endfunction

    for (genvar j = 1; j <= DSTG; j++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (en[S_DIV0+j])
                dp_reg[j] <= dp_adv(dp_reg[j-1]);
        end
    end

    // normalized coordinates
    logic [W-1:0]        qmag;
    logic signed [W:0]   nsig;
    logic signed [W-1:0] n_next [0:2];

    always_comb
    begin
        qmag = '0;
        nsig = '0;
        for (int i = 0; i < 3; i++)
        begin
            qmag = dp_reg[DSTG].ovf[i] ? {1'b1, {(W-1){1'b0}}}
                                       : W'(((W+1)'(dp_reg[DSTG].ln[i].q) + (W+1)'(1)) >> 1);
            nsig = dp_reg[DSTG].neg[i] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
            n_next[i] = sat_w(SATW'(nsig));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_N])
        begin
            wz_n_reg <= dp_reg[DSTG].wz;
            for (int i = 0; i < 3; i++)
                n_reg[i] <= n_next[i];
        end
    end

    // viewport scale
    logic signed [W:0] ax, ay;

    always_comb
    begin
        ax = (W+1)'(n_reg[0]) + ONE_Q;
        ay = (W+1)'(n_reg[1]) + ONE_Q;
    end

    always_ff @(posedge clk)
    begin
        if (en[S_PROD])
        begin
            wz_p_reg <= wz_n_reg;
            px_reg   <= ax * $signed({1'b0, vp_w_reg});
            py_reg   <= ay * $signed({1'b0, vp_h_reg});
            pz_reg   <= (W+1)'(n_reg[2]) + ONE_Q;
        end
    end

    // halve with ties away from zero, add origin, saturate
    logic signed [W+16:0]   hx, hy;
    logic signed [W:0]      hz;
    logic signed [SATW-1:0] sx, sy;

    always_comb
    begin
        hx = (px_reg + $signed((W+17)'(!px_reg[W+16]))) >>> 1;
        hy = (py_reg + $signed((W+17)'(!py_reg[W+16]))) >>> 1;
        hz = (pz_reg + $signed((W+1)'(!pz_reg[W]))) >>> 1;
        sx = SATW'(hx) + (SATW'(org_x_reg) <<< FRAC_BITS);
        sy = SATW'(hy) + (SATW'(org_y_reg) <<< FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en[NST])
        begin
            ok_reg <= !wz_p_reg;
            wx_reg <= wz_p_reg ? '0 : sat_w(sx);
            wy_reg <= wz_p_reg ? '0 : sat_w(sy);
            wz_reg <= wz_p_reg ? '0 : sat_w(SATW'(hz));
        end
    end

    assign s_tready = en[1];
    assign m_tvalid = v_reg[NST];
    assign m_tuser  = ok_reg;
    assign m_tdata  = {wz_reg, wy_reg, wx_reg};

endmodule
